// File: design/tvtb_pkg.sv
// Shared types, constants and sine table builder for the triangle transform core.
`default_nettype none

package tvtb_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam int SCALE_W = 16;
  localparam int ANGLE_W = 9;
  localparam int OFS_W   = 12;
  localparam int SURF_W  = 13;
  localparam int TRIG_W  = 16;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 13;

  // pipeline depth: trig/input, 6 lane stages, 2 merge stages
  localparam int NSTAGE     = 9;
  localparam int LANE_FIRST = 0;
  localparam int MERGE_MIN  = 7;
  localparam int MERGE_OUT  = 8;

  localparam logic [OFS_W-1:0]  OFFSET_X_RST = OFS_W'(1024 / 2);
  localparam logic [OFS_W-1:0]  OFFSET_Y_RST = OFS_W'(768 / 2);
  localparam logic [SURF_W-1:0] SURF_W_RST   = SURF_W'(1024);
  localparam logic [SURF_W-1:0] SURF_H_RST   = SURF_W'(768);

  localparam logic [ANGLE_W-1:0] DEG_FULL    = ANGLE_W'(360);
  localparam logic [ANGLE_W-1:0] DEG_HALF    = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] DEG_QUARTER = ANGLE_W'(90);
  localparam logic [ANGLE_W-1:0] DEG_3Q      = ANGLE_W'(270);

  typedef enum logic [CFG_AW-1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_SURF_W   = 2'd2,
    REG_SURF_H   = 2'd3
  } cfg_reg_t;

  typedef logic [NSTAGE-1:0] stage_en_t;

  typedef struct packed {
    logic [OFS_W-1:0]  offset_x;
    logic [OFS_W-1:0]  offset_y;
    logic [SURF_W-1:0] surf_w;
    logic [SURF_W-1:0] surf_h;
  } cfg_t;

  typedef logic [14:0] sin_tab_t [0:90];

  typedef struct packed {
    logic [6:0] idx;
    logic       neg;
  } quad_t;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] SER_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210, 64'd272};

  // sine of d degrees (0..90) in Q1.14 by a fixed-point series
  function automatic logic [14:0] sin_q1_calc(input int unsigned d);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    x = (PI_Q30 * 64'(d)) / 64'd180;
    x2 = (x * x) >> 30;
    term = x;
    sum = signed'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / SER_DIV[k];
      if (k % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    rnd = ((unsigned'(sum) << 14) + (64'd1 << 29)) >> 30;
    return rnd[14:0];
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    for (int d = 0; d <= 90; d++) begin
      t[d] = sin_q1_calc(d);
    end
    return t;
  endfunction

  // fold an angle in 0..359 onto the first quadrant
  function automatic quad_t fold_angle(input logic [ANGLE_W-1:0] d);
    quad_t q;
    logic [ANGLE_W-1:0] r;
    if (d <= DEG_QUARTER) begin
      r = d;
      q.neg = 1'b0;
    end else if (d <= DEG_HALF) begin
      r = DEG_HALF - d;
      q.neg = 1'b0;
    end else if (d <= DEG_3Q) begin
      r = d - DEG_HALF;
      q.neg = 1'b1;
    end else begin
      r = DEG_FULL - d;
      q.neg = 1'b1;
    end
    q.idx = r[6:0];
    return q;
  endfunction

endpackage

`default_nettype wire

// File: design/triangle_vertex_transform_bbox_core.sv
// Top level: triangle vertex transform with bounding box, three vertex lanes.
//
//  channel   dir  handshake            payload
//  in_       in   in_tvalid/in_tready  in_tdata: vertices, scale, angle
//  out_      out  out_tvalid/out_tready out_tdata: screen vertices, box, inside
//  cfg_      in   cfg_wr_en            cfg_addr, cfg_wdata
//
// One item per cycle while out_tready is high; stages: trig lookup, six lane stages
// (scale multiply, truncate, rotate multiply, sum, offset, saturate), min/max, output.
// Each stage holds its own valid bit and loads when empty or when its successor moves,
// so bubbles close up under output stall. Synchronous active-low reset clears the
// valid bits and loads the register reset values.
`default_nettype none

module triangle_vertex_transform_bbox_core #(
  parameter int COORD_BITS = tvtb_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((6 * COORD_BITS + tvtb_pkg::SCALE_W + tvtb_pkg::ANGLE_W + 7) / 8) * 8,
  localparam int OUT_W = ((10 * COORD_BITS + 1 + 7) / 8) * 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // ax, ay, bx, by, cx, cy, scale_factor, angle_deg
  input  wire logic [IN_W-1:0]              in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // screen_ax, screen_ay, screen_bx, screen_by, screen_cx, screen_cy,
  // box_left, box_top, box_width, box_height, inside_res
  output logic [OUT_W-1:0]                  out_tdata,
  input  wire logic                         cfg_wr_en,
  input  wire logic [tvtb_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [tvtb_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int CB = COORD_BITS;

  tvtb_pkg::cfg_t       cfg_r, cfg_nxt;
  tvtb_pkg::cfg_reg_t   cfg_sel;

  logic [tvtb_pkg::NSTAGE-1:0] vld_r, vld_nxt;
  logic [tvtb_pkg::NSTAGE:0]   rdy;
  tvtb_pkg::stage_en_t         en;

  logic signed [CB-1:0]               mx [3];
  logic signed [CB-1:0]               my [3];
  logic [tvtb_pkg::SCALE_W-1:0]       scale;
  logic [tvtb_pkg::ANGLE_W-1:0]       angle;
  logic signed [tvtb_pkg::TRIG_W-1:0] sin_r, cos_r;

  logic signed [CB-1:0] lx [3];
  logic signed [CB-1:0] ly [3];
  logic [2:0]           lin;

  logic signed [CB-1:0] sx [3];
  logic signed [CB-1:0] sy [3];
  logic signed [CB-1:0] box_left, box_top;
  logic [CB-1:0]        box_width, box_height;
  logic                 inside_res;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    cfg_sel = tvtb_pkg::cfg_reg_t'(cfg_addr);
    if (cfg_wr_en) begin
      unique case (cfg_sel)
        tvtb_pkg::REG_OFFSET_X: cfg_nxt.offset_x = cfg_wdata[tvtb_pkg::OFS_W-1:0];
        tvtb_pkg::REG_OFFSET_Y: cfg_nxt.offset_y = cfg_wdata[tvtb_pkg::OFS_W-1:0];
        tvtb_pkg::REG_SURF_W:   cfg_nxt.surf_w   = cfg_wdata[tvtb_pkg::SURF_W-1:0];
        tvtb_pkg::REG_SURF_H:   cfg_nxt.surf_h   = cfg_wdata[tvtb_pkg::SURF_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_x <= tvtb_pkg::OFFSET_X_RST;
      cfg_r.offset_y <= tvtb_pkg::OFFSET_Y_RST;
      cfg_r.surf_w   <= tvtb_pkg::SURF_W_RST;
      cfg_r.surf_h   <= tvtb_pkg::SURF_H_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // per-stage valid chain
  always_comb begin
    rdy[tvtb_pkg::NSTAGE] = out_tready;
    for (int k = tvtb_pkg::NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    for (int k = 0; k < tvtb_pkg::NSTAGE; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
    en = rdy[tvtb_pkg::NSTAGE-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[tvtb_pkg::NSTAGE-1];

  // input unpack
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mx[i] = in_tdata[2*i*CB +: CB];
      my[i] = in_tdata[(2*i+1)*CB +: CB];
    end
    scale = in_tdata[6*CB +: tvtb_pkg::SCALE_W];
    angle = in_tdata[6*CB + tvtb_pkg::SCALE_W +: tvtb_pkg::ANGLE_W];
  end

  tvtb_trig u_trig (
    .clk   (clk),
    .en    (en[tvtb_pkg::LANE_FIRST]),
    .angle (angle),
    .sin_r (sin_r),
    .cos_r (cos_r)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    tvtb_lane #(.CB(CB)) u_lane (
      .clk      (clk),
      .en       (en),
      .mx       (mx[g]),
      .my       (my[g]),
      .scale    (scale),
      .sin_v    (sin_r),
      .cos_v    (cos_r),
      .cfg      (cfg_r),
      .x_r      (lx[g]),
      .y_r      (ly[g]),
      .inside_r (lin[g])
    );
  end

  tvtb_merge #(.CB(CB)) u_merge (
    .clk      (clk),
    .en       (en),
    .vx       (lx),
    .vy       (ly),
    .vin      (lin),
    .sx_r     (sx),
    .sy_r     (sy),
    .left_r   (box_left),
    .top_r    (box_top),
    .width_r  (box_width),
    .height_r (box_height),
    .inside_r (inside_res)
  );

  assign out_tdata = OUT_W'({inside_res, box_height, box_width, box_top, box_left,
                             sy[2], sx[2], sy[1], sx[1], sy[0], sx[0]});

endmodule

`default_nettype wire

// File: design/tvtb_trig.sv
// Angle reduction and sine/cosine table lookup, one registered stage.
`default_nettype none

module tvtb_trig (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [tvtb_pkg::ANGLE_W-1:0]      angle,
  output logic signed [tvtb_pkg::TRIG_W-1:0]     sin_r,
  output logic signed [tvtb_pkg::TRIG_W-1:0]     cos_r
);

  localparam tvtb_pkg::sin_tab_t SIN_TAB = tvtb_pkg::build_sin_tab();

  logic [tvtb_pkg::ANGLE_W-1:0]         ang_m;
  logic [tvtb_pkg::ANGLE_W-1:0]         ang_c;
  logic [tvtb_pkg::ANGLE_W-1:0]         ang_c90;
  tvtb_pkg::quad_t                      qs;
  tvtb_pkg::quad_t                      qc;
  logic signed [tvtb_pkg::TRIG_W-1:0]   sin_nxt;
  logic signed [tvtb_pkg::TRIG_W-1:0]   cos_nxt;
  logic signed [tvtb_pkg::TRIG_W-1:0]   sin_mag;
  logic signed [tvtb_pkg::TRIG_W-1:0]   cos_mag;

  always_comb begin
    ang_m   = (angle >= tvtb_pkg::DEG_FULL) ? angle - tvtb_pkg::DEG_FULL : angle;
    ang_c90 = ang_m + tvtb_pkg::DEG_QUARTER;
    ang_c   = (ang_c90 >= tvtb_pkg::DEG_FULL) ? ang_c90 - tvtb_pkg::DEG_FULL : ang_c90;
    qs      = tvtb_pkg::fold_angle(ang_m);
    qc      = tvtb_pkg::fold_angle(ang_c);
    sin_mag = $signed({1'b0, SIN_TAB[qs.idx]});
    cos_mag = $signed({1'b0, SIN_TAB[qc.idx]});
    sin_nxt = qs.neg ? -sin_mag : sin_mag;
    cos_nxt = qc.neg ? -cos_mag : cos_mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/tvtb_lane.sv
// One vertex lane: scale, rotate, translate, saturate and surface check.
`default_nettype none

module tvtb_lane #(
  parameter int CB = tvtb_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire tvtb_pkg::stage_en_t                en,
  input  wire logic signed [CB-1:0]               mx,
  input  wire logic signed [CB-1:0]               my,
  input  wire logic [tvtb_pkg::SCALE_W-1:0]       scale,
  input  wire logic signed [tvtb_pkg::TRIG_W-1:0] sin_v,
  input  wire logic signed [tvtb_pkg::TRIG_W-1:0] cos_v,
  input  wire tvtb_pkg::cfg_t                     cfg,
  output logic signed [CB-1:0]                    x_r,
  output logic signed [CB-1:0]                    y_r,
  output logic                                    inside_r
);

  localparam int PW   = CB + tvtb_pkg::SCALE_W + 1;
  localparam int SW   = PW - 8;
  localparam int MW   = SW + tvtb_pkg::TRIG_W;
  localparam int SUMW = MW + 1;
  localparam int QW   = SUMW - 14;
  localparam int TW   = QW + 1;
  localparam int CMPW = (CB > tvtb_pkg::SURF_W) ? CB : tvtb_pkg::SURF_W;

  localparam logic signed [TW-1:0] SAT_HI = {{(TW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [TW-1:0] SAT_LO = {{(TW-CB+1){1'b1}}, {(CB-1){1'b0}}};

  function automatic logic signed [CB-1:0] sat(input logic signed [TW-1:0] v);
    logic signed [CB-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[CB-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CB-1:0];
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  function automatic logic in_range(input logic signed [CB-1:0] v,
                                    input logic [tvtb_pkg::SURF_W-1:0] lim);
    logic [CB-1:0] vu;
    vu = v;
    return !v[CB-1] && (CMPW'(vu) < CMPW'(lim));
  endfunction

  logic signed [CB-1:0]               mx0_r, my0_r;
  logic [tvtb_pkg::SCALE_W-1:0]       sc0_r;
  logic signed [PW-1:0]               px1_r, py1_r;
  logic signed [tvtb_pkg::TRIG_W-1:0] sn1_r, cs1_r, sn2_r, cs2_r;
  logic signed [SW-1:0]               sx2_r, sy2_r;
  logic signed [MW-1:0]               mcx3_r, msy3_r, msx3_r, mcy3_r;
  logic signed [SUMW-1:0]             sumx4_r, sumy4_r;
  logic signed [TW-1:0]               tx5_r, ty5_r;

  logic [PW-1:0]        adjx1, adjy1;
  logic [SUMW-1:0]      adjx4, adjy4;
  logic signed [QW-1:0] qx4, qy4;
  logic signed [CB-1:0] xs5, ys5;

  always_comb begin
    adjx1 = px1_r + (px1_r[PW-1] ? PW'(255) : '0);
    adjy1 = py1_r + (py1_r[PW-1] ? PW'(255) : '0);
    adjx4 = sumx4_r + (sumx4_r[SUMW-1] ? SUMW'(16383) : '0);
    adjy4 = sumy4_r + (sumy4_r[SUMW-1] ? SUMW'(16383) : '0);
    qx4   = adjx4[SUMW-1:14];
    qy4   = adjy4[SUMW-1:14];
    xs5   = sat(tx5_r);
    ys5   = sat(ty5_r);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mx0_r <= mx;
      my0_r <= my;
      sc0_r <= scale;
    end
    if (en[1]) begin
      px1_r <= mx0_r * $signed({1'b0, sc0_r});
      py1_r <= my0_r * $signed({1'b0, sc0_r});
      sn1_r <= sin_v;
      cs1_r <= cos_v;
    end
    if (en[2]) begin
      sx2_r <= adjx1[PW-1:8];
      sy2_r <= adjy1[PW-1:8];
      sn2_r <= sn1_r;
      cs2_r <= cs1_r;
    end
    if (en[3]) begin
      mcx3_r <= cs2_r * sx2_r;
      msy3_r <= sn2_r * sy2_r;
      msx3_r <= sn2_r * sx2_r;
      mcy3_r <= cs2_r * sy2_r;
    end
    if (en[4]) begin
      sumx4_r <= SUMW'(mcx3_r) - SUMW'(msy3_r);
      sumy4_r <= SUMW'(msx3_r) + SUMW'(mcy3_r);
    end
    if (en[5]) begin
      tx5_r <= TW'(qx4) + TW'($signed({1'b0, cfg.offset_x}));
      ty5_r <= TW'(qy4) + TW'($signed({1'b0, cfg.offset_y}));
    end
    if (en[6]) begin
      x_r      <= xs5;
      y_r      <= ys5;
      inside_r <= in_range(xs5, cfg.surf_w) && in_range(ys5, cfg.surf_h);
    end
  end

endmodule

`default_nettype wire

// File: design/tvtb_merge.sv
// Merges the three lanes: bounding box and combined inside flag.
`default_nettype none

module tvtb_merge #(
  parameter int CB = tvtb_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire tvtb_pkg::stage_en_t   en,
  input  wire logic signed [CB-1:0]  vx [3],
  input  wire logic signed [CB-1:0]  vy [3],
  input  wire logic [2:0]            vin,
  output logic signed [CB-1:0]       sx_r [3],
  output logic signed [CB-1:0]       sy_r [3],
  output logic signed [CB-1:0]       left_r,
  output logic signed [CB-1:0]       top_r,
  output logic [CB-1:0]              width_r,
  output logic [CB-1:0]              height_r,
  output logic                       inside_r
);

  logic signed [CB-1:0] vx7_r [3];
  logic signed [CB-1:0] vy7_r [3];
  logic signed [CB-1:0] minx7_r, maxx7_r, miny7_r, maxy7_r;
  logic                 in7_r;

  logic signed [CB-1:0] mnx01, mxx01, mny01, mxy01;
  logic signed [CB-1:0] mnx, mxx, mny, mxy;
  logic [CB-1:0]        wdt, hgt;

  always_comb begin
    mnx01 = (vx[1] < vx[0]) ? vx[1] : vx[0];
    mxx01 = (vx[1] > vx[0]) ? vx[1] : vx[0];
    mny01 = (vy[1] < vy[0]) ? vy[1] : vy[0];
    mxy01 = (vy[1] > vy[0]) ? vy[1] : vy[0];
    mnx   = (vx[2] < mnx01) ? vx[2] : mnx01;
    mxx   = (vx[2] > mxx01) ? vx[2] : mxx01;
    mny   = (vy[2] < mny01) ? vy[2] : mny01;
    mxy   = (vy[2] > mxy01) ? vy[2] : mxy01;
    wdt   = maxx7_r - minx7_r;
    hgt   = maxy7_r - miny7_r;
  end

  always_ff @(posedge clk) begin
    if (en[tvtb_pkg::MERGE_MIN]) begin
      vx7_r   <= vx;
      vy7_r   <= vy;
      minx7_r <= mnx;
      maxx7_r <= mxx;
      miny7_r <= mny;
      maxy7_r <= mxy;
      in7_r   <= &vin;
    end
    if (en[tvtb_pkg::MERGE_OUT]) begin
      sx_r     <= vx7_r;
      sy_r     <= vy7_r;
      left_r   <= minx7_r;
      top_r    <= miny7_r;
      width_r  <= wdt;
      height_r <= hgt;
      inside_r <= in7_r;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking stream testbench for the triangle vertex transform and bounding box core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_BITS   = 128;
  localparam int OUT_BITS  = 168;
  localparam int STALL_CAP = 2000;
  localparam int DRAIN_CYC = 20;
  localparam longint unsigned PI_Q30_VAL = 64'd3373259426;

  // packed so that ax lands in the lowest bits of tdata
  typedef struct packed {
    logic [8:0]         angle;
    logic [15:0]        scale;
    logic signed [15:0] cy, cx, by, bx, ay, ax;
  } tri_item_t;

  typedef struct packed {
    logic               on_surface;
    logic [15:0]        height, width;
    logic signed [15:0] top, left;
    logic signed [15:0] cy, cx, by, bx, ay, ax;
  } tri_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [IN_BITS-1:0]            in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [OUT_BITS-1:0]           out_tdata;
  logic                          cfg_wr_en = 1'b0;
  logic [tvtb_pkg::CFG_AW-1:0]   cfg_addr = '0;
  logic [tvtb_pkg::CFG_DW-1:0]   cfg_wdata = '0;

  triangle_vertex_transform_bbox_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the transform registers
  longint ofs_x  = 512;
  longint ofs_y  = 384;
  longint surf_w = 1024;
  longint surf_h = 768;

  tri_item_t   pending_tris[$];
  tri_result_t expected_views[$];
  tri_item_t   cur_tri;
  tri_result_t got_view;
  tri_result_t want_view;

  int  queued_cnt   = 0;
  int  accepted_cnt = 0;
  int  checked_cnt  = 0;
  int  inside_hits  = 0;
  int  cfg_writes   = 0;
  int  errors       = 0;
  int  send_gap     = 0;
  int  recv_gap     = 0;
  int  hold_left    = 0;
  int  taken        = 0;
  int  stall_cycles = 0;
  bit  hold_done    = 1'b0;
  bit  quiet        = 1'b0;

  // Q1.14 sine for 0..90 degrees via a truncated Taylor series in Q30
  function automatic longint quarter_sine(int unsigned deg);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint          acc;
    ang = (PI_Q30_VAL * deg) / 180;
    ang_sq = (ang * ang) >> 30;
    term = ang;
    acc = longint'(ang);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * ang_sq) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return longint'(((unsigned'(acc) << 14) + (64'd1 << 29)) >> 30);
  endfunction

  function automatic longint sine_deg(int unsigned deg);
    int unsigned d;
    d = deg % 360;
    if (d <= 90) begin
      return quarter_sine(d);
    end else if (d <= 180) begin
      return quarter_sine(180 - d);
    end else if (d <= 270) begin
      return -quarter_sine(d - 180);
    end
    return -quarter_sine(360 - d);
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic tri_result_t project_triangle(tri_item_t t);
    tri_result_t        r;
    logic signed [15:0] mx[3];
    logic signed [15:0] my[3];
    longint             px[3];
    longint             py[3];
    longint             sn, cs, sx, sy, rx, ry;
    longint             lo_x, hi_x, lo_y, hi_y;
    int unsigned        a;
    bit                 in_view;
    mx = '{t.ax, t.bx, t.cx};
    my = '{t.ay, t.by, t.cy};
    a = int'(t.angle) % 360;
    sn = sine_deg(a);
    cs = sine_deg(a + 90);
    in_view = 1'b1;
    for (int i = 0; i < 3; i++) begin
      sx = (longint'(mx[i]) * longint'(t.scale)) / 256;
      sy = (longint'(my[i]) * longint'(t.scale)) / 256;
      rx = (cs * sx - sn * sy) / 16384;
      ry = (sn * sx + cs * sy) / 16384;
      px[i] = clamp16(rx + ofs_x);
      py[i] = clamp16(ry + ofs_y);
      if (px[i] < 0 || px[i] >= surf_w || py[i] < 0 || py[i] >= surf_h) begin
        in_view = 1'b0;
      end
    end
    lo_x = px[0];
    hi_x = px[0];
    lo_y = py[0];
    hi_y = py[0];
    for (int i = 1; i < 3; i++) begin
      if (px[i] < lo_x) lo_x = px[i];
      if (px[i] > hi_x) hi_x = px[i];
      if (py[i] < lo_y) lo_y = py[i];
      if (py[i] > hi_y) hi_y = py[i];
    end
    r.ax = 16'(px[0]);
    r.ay = 16'(py[0]);
    r.bx = 16'(px[1]);
    r.by = 16'(py[1]);
    r.cx = 16'(px[2]);
    r.cy = 16'(py[2]);
    r.left = 16'(lo_x);
    r.top = 16'(lo_y);
    r.width = 16'(hi_x - lo_x);
    r.height = 16'(hi_y - lo_y);
    r.on_surface = in_view;
    return r;
  endfunction

  function automatic tri_item_t make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                         int scale, int angle);
    tri_item_t t;
    t.ax = 16'(ax);
    t.ay = 16'(ay);
    t.bx = 16'(bx);
    t.by = 16'(by);
    t.cx = 16'(cx);
    t.cy = 16'(cy);
    t.scale = 16'(scale);
    t.angle = 9'(angle);
    return t;
  endfunction

  function automatic logic [15:0] pick_coord(int kind);
    if (kind < 5) begin
      return 16'($urandom_range(0, 600) - 300);
    end else if (kind < 7) begin
      return 16'($urandom_range(0, 8000) - 4000);
    end else if (kind < 9) begin
      return 16'($urandom_range(0, 65535));
    end
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  // half near-unit scale triangles of small extent, plus wide and corner cases
  function automatic tri_item_t random_triangle();
    tri_item_t t;
    int        kind;
    kind = $urandom_range(0, 9);
    t.ax = pick_coord(kind);
    t.ay = pick_coord(kind);
    t.bx = pick_coord(kind);
    t.by = pick_coord(kind);
    t.cx = pick_coord(kind);
    t.cy = pick_coord(kind);
    if (kind < 5) begin
      t.scale = 16'($urandom_range(128, 512));
    end else if (kind < 9) begin
      t.scale = 16'($urandom_range(0, 65535));
    end else begin
      case ($urandom_range(0, 4))
        0: t.scale = 16'd0;
        1: t.scale = 16'd1;
        2: t.scale = 16'd255;
        3: t.scale = 16'd256;
        default: t.scale = 16'hFFFF;
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      t.angle = 9'($urandom_range(360, 511));
    end else begin
      t.angle = 9'($urandom_range(0, 359));
    end
    return t;
  endfunction

  task automatic write_reg(tvtb_pkg::cfg_reg_t idx, logic [tvtb_pkg::CFG_DW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_writes++;
    case (idx)
      tvtb_pkg::REG_OFFSET_X: ofs_x = longint'(val[11:0]);
      tvtb_pkg::REG_OFFSET_Y: ofs_y = longint'(val[11:0]);
      tvtb_pkg::REG_SURF_W:   surf_w = longint'(val);
      tvtb_pkg::REG_SURF_H:   surf_h = longint'(val);
      default: ;
    endcase
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      pending_tris.push_back(random_triangle());
    end
    queued_cnt += n;
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || expected_views.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic compare_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_views.push_back(project_triangle(cur_tri));
        accepted_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 3);
          in_tvalid <= 1'b0;
        end else if (pending_tris.size() > 0) begin
          cur_tri = pending_tris.pop_front();
          in_tdata <= {7'b0, cur_tri};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off once the run is under way
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && taken >= 40) begin
        hold_done = 1'b1;
        hold_left = 80;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_view = out_tdata[160:0];
      if (expected_views.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %0h", $time, got_view);
        errors++;
      end else begin
        want_view = expected_views.pop_front();
        compare_field("screen_ax", want_view.ax, got_view.ax);
        compare_field("screen_ay", want_view.ay, got_view.ay);
        compare_field("screen_bx", want_view.bx, got_view.bx);
        compare_field("screen_by", want_view.by, got_view.by);
        compare_field("screen_cx", want_view.cx, got_view.cx);
        compare_field("screen_cy", want_view.cy, got_view.cy);
        compare_field("box_left", want_view.left, got_view.left);
        compare_field("box_top", want_view.top, got_view.top);
        compare_field("box_width", want_view.width, got_view.width);
        compare_field("box_height", want_view.height, got_view.height);
        compare_field("inside_res", 16'(want_view.on_surface), 16'(got_view.on_surface));
        checked_cnt++;
        if (got_view.on_surface) begin
          inside_hits++;
        end
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_CAP) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed triangles at reset settings
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 100, 0, 0, 100, 256, 0));
    pending_tris.push_back(make_tri(0, 0, 100, 0, 0, 100, 256, 90));
    pending_tris.push_back(make_tri(0, 0, 100, 0, 0, 100, 256, 180));
    pending_tris.push_back(make_tri(0, 0, 100, 0, 0, 100, 256, 270));
    pending_tris.push_back(make_tri(0, 0, 100, 0, 0, 100, 256, 45));
    pending_tris.push_back(make_tri(0, 0, 100, 0, 0, 100, 256, 359));
    pending_tris.push_back(make_tri(0, 0, 100, 0, 0, 100, 256, 360));
    pending_tris.push_back(make_tri(0, 0, 100, 0, 0, 100, 256, 450));
    pending_tris.push_back(make_tri(0, 0, 100, 0, 0, 100, 256, 511));
    pending_tris.push_back(make_tri(511, 383, -512, -384, 0, 0, 256, 0));
    pending_tris.push_back(make_tri(512, 0, 0, 384, 0, 0, 256, 0));
    pending_tris.push_back(make_tri(-513, 0, 0, -385, 0, 0, 256, 0));
    pending_tris.push_back(make_tri(32767, 32767, -32768, -32768, 0, 0, 65535, 0));
    pending_tris.push_back(make_tri(32767, 32767, -32768, -32768, 0, 0, 65535, 45));
    pending_tris.push_back(make_tri(-32768, 32767, 32767, -32768, -1, 1, 65535, 135));
    pending_tris.push_back(make_tri(-1, -1, 1, 1, -255, 255, 1, 0));
    pending_tris.push_back(make_tri(-3, 7, 5, -9, 11, -13, 65535, 30));
    pending_tris.push_back(make_tri(1000, -1000, -700, 300, 250, 250, 384, 60));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, -32768, -32768, -32768, 256, 0));
    pending_tris.push_back(make_tri(32767, 32767, 32767, 32767, 32767, 32767, 256, 90));
    pending_tris.push_back(make_tri(12345, -23456, -5000, 5000, 1, -1, 65280, 225));
    queued_cnt += 22;
    wait_drained();

    queue_random(120);
    wait_drained();

    // no vertex can be inside a zero-width surface
    write_reg(tvtb_pkg::REG_OFFSET_X, 13'd0);
    write_reg(tvtb_pkg::REG_OFFSET_Y, 13'd0);
    write_reg(tvtb_pkg::REG_SURF_W, 13'd0);
    write_reg(tvtb_pkg::REG_SURF_H, 13'd1);
    queue_random(60);
    wait_drained();

    write_reg(tvtb_pkg::REG_OFFSET_X, 13'd4095);
    write_reg(tvtb_pkg::REG_OFFSET_Y, 13'd4095);
    write_reg(tvtb_pkg::REG_SURF_W, 13'd4096);
    write_reg(tvtb_pkg::REG_SURF_H, 13'd4096);
    queue_random(60);
    wait_drained();

    // surface larger than the nominal maximum
    write_reg(tvtb_pkg::REG_OFFSET_X, 13'($urandom_range(0, 4095)));
    write_reg(tvtb_pkg::REG_OFFSET_Y, 13'($urandom_range(0, 4095)));
    write_reg(tvtb_pkg::REG_SURF_W, 13'd8191);
    write_reg(tvtb_pkg::REG_SURF_H, 13'd8191);
    queue_random(60);
    wait_drained();

    write_reg(tvtb_pkg::REG_OFFSET_X, 13'($urandom_range(0, 4095)));
    write_reg(tvtb_pkg::REG_OFFSET_Y, 13'($urandom_range(0, 4095)));
    write_reg(tvtb_pkg::REG_SURF_W, 13'($urandom_range(1, 4096)));
    write_reg(tvtb_pkg::REG_SURF_H, 13'($urandom_range(1, 4096)));
    quiet = 1'b1;
    queue_random(100);
    wait_drained();

    repeat (DRAIN_CYC) @(posedge clk);
    if (expected_views.size() != 0) begin
      $display("%0t: %0d items still expected at end", $time, expected_views.size());
      errors++;
    end
    $display("Sent %0d triangles over %0d register writes (offsets and surface extremes).",
             accepted_cnt, cfg_writes);
    $display("Checked %0d results, %0d fully on surface, %0d errors.",
             checked_cnt, inside_hits, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
